FILE: hdl/pltlru_pkg.sv
// Package for the per-tenant LRU page table.
// Holds action and status codes, the cell command, the state type and the transfer types;
// no dependencies.
package pltlru_pkg;
	localparam int ACTION_W = 3;
	localparam int TENANT_W = 4;
	localparam int PAGE_W   = 20;
	localparam int LOC_W    = 11;
	localparam int STATUS_W = 3;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOOKUP = 3'd0,
		ACT_TOUCH  = 3'd1,
		ACT_ADD    = 3'd2,
		ACT_EVICT  = 3'd3,
		ACT_ALLOC  = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_MISSING = 3'd1,
		ST_PRESENT = 3'd2,
		ST_EMPTY_T = 3'd3,
		ST_POOL_MT = 3'd4
	} status_t;

	// Command broadcast to every cell for one cycle.
	typedef enum logic [1:0] {
		CC_NONE  = 2'd0,
		CC_PUSH  = 2'd1,   // shift right up to and including the marked slot
		CC_CLOSE = 2'd2    // shift left from the marked slot upward
	} cell_cmd_t;

	typedef enum logic [2:0] {
		FS_IDLE   = 3'd0,
		FS_SEARCH = 3'd1,
		FS_APPLY  = 3'd2,
		FS_RELOAD = 3'd3,
		FS_OUT    = 3'd4
	} fsm_t;

	// Request transfer
	typedef struct packed {
		action_t             action;
		logic [TENANT_W-1:0] tenant;
		logic [PAGE_W-1:0]   page_number;
		logic [LOC_W-1:0]    new_location;
	} page_req_t;

	// Response transfer
	typedef struct packed {
		logic [LOC_W-1:0]  location;
		logic              hit;
		logic [PAGE_W-1:0] victim_page;
		status_t           status;
	} page_rsp_t;

	// Configuration transfer: slots_in_use
	typedef logic [LOC_W-1:0] slots_t;
endpackage

FILE: hdl/pltlru_if.sv
// Valid/ready channel interface for the page table.
// Depends on nothing; the payload type is a parameter.
interface pltlru_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/pltlru_cell.sv
// One recency cell: valid, tenant, page, location.
// Depends on pltlru_pkg.
module pltlru_cell #(
	parameter int PAGE_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pltlru_pkg::cell_cmd_t         cmd,
	input  logic                          shift_en,   // this cell takes its neighbour
	input  logic                          load_head,  // head cell loads the new entry
	input  logic                          nb_valid,
	input  logic [pltlru_pkg::TENANT_W-1:0] nb_tenant,
	input  logic [PAGE_BITS-1:0]          nb_page,
	input  logic [pltlru_pkg::LOC_W-1:0]  nb_loc,
	input  logic [pltlru_pkg::TENANT_W-1:0] key_tenant,
	input  logic [PAGE_BITS-1:0]          key_page,
	output logic                          valid_q,
	output logic [pltlru_pkg::TENANT_W-1:0] tenant_q,
	output logic [PAGE_BITS-1:0]          page_q,
	output logic [pltlru_pkg::LOC_W-1:0]  loc_q,
	output logic                          match,
	output logic                          tmatch
);
	assign tmatch = valid_q && tenant_q == key_tenant;
	assign match  = tmatch && page_q == key_page;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd != pltlru_pkg::CC_NONE && (shift_en || load_head)) begin
			valid_q <= nb_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd != pltlru_pkg::CC_NONE && (shift_en || load_head)) begin
			tenant_q <= nb_tenant;
			page_q   <= nb_page;
			loc_q    <= nb_loc;
		end
	end
endmodule

FILE: hdl/pltlru_pool.sv
// Free-location ring of the page table, as a memory with a reload sweep.
// Depends on pltlru_pkg.
module pltlru_pool #(
	parameter int SLOTS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         reload,     // start reload with count
	input  logic [pltlru_pkg::LOC_W-1:0] count_in,
	input  logic                         pop,
	output logic                         busy,
	output logic                         empty,
	output logic [pltlru_pkg::LOC_W-1:0] head_loc_q
);
	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	logic [pltlru_pkg::LOC_W-1:0] ring [SLOTS];
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] lim_q;
	logic          busy_q;
	logic [CW-1:0] lim_c;

	always_comb begin
		lim_c = (CW'(count_in) > CW'(SLOTS)) ? CW'(SLOTS) : CW'(count_in);
		if (CW < pltlru_pkg::LOC_W && count_in > pltlru_pkg::LOC_W'(SLOTS)) lim_c = CW'(SLOTS);
	end

	assign busy  = busy_q;
	assign empty = count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			fill_q  <= '0;
			lim_q   <= (CW'(1024) > CW'(SLOTS)) ? CW'(SLOTS) : CW'(1024);
			head_q  <= '0;
			count_q <= '0;
		end else if (reload) begin
			busy_q  <= 1'b1;
			fill_q  <= '0;
			lim_q   <= lim_c;
			head_q  <= '0;
			count_q <= '0;
		end else if (busy_q) begin
			if (fill_q == CW'(SLOTS) - 1'b1) begin
				busy_q  <= 1'b0;
				count_q <= lim_q;
			end
			fill_q <= fill_q + 1'b1;
		end else if (pop && !empty) begin
			head_q  <= (head_q == AW'(SLOTS - 1)) ? '0 : head_q + 1'b1;
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !reload) begin
			ring[fill_q[AW-1:0]] <= (fill_q < lim_q) ?
				pltlru_pkg::LOC_W'(fill_q + 1'b1) : '0;
		end
		head_loc_q <= ring[head_q];
	end
endmodule

FILE: hdl/per_tenant_lru_page_table.sv
// Top level of the per-tenant LRU page table.
// Depends on pltlru_pkg, pltlru_if, pltlru_cell and pltlru_pool.
//
// Usage
//  - req (sink): action, tenant, page_number, new_location. One transfer is
//    one request; exactly one rsp transfer follows for each.
//  - rsp (source): location, hit, victim_page, status, held in an output
//    register until the receiver takes it; the next request is taken while
//    it waits.
//  - cfg (sink): slots_in_use. A transfer reloads the free ring with
//    1..slots_in_use (saturated to BUFFER_SLOTS); cells are untouched.
// Timing
//  - A request walks four states: accept, search of all cells in parallel,
//    one shift of the cell chain, output register load. Requests never
//    overlap: the next is accepted only once this one is back in accept.
//  - Allocate reads the ring memory through its registered read port.
// Reset
//  - All cells go invalid at once. The free ring is then filled by a sweep over
//    every ring entry, during which req is not ready; a cfg write starts
//    the same sweep again.
// Stall
//  - If rsp is held, a further request waits before the output stage.
module per_tenant_lru_page_table #(
	parameter int BUFFER_SLOTS = 1024,
	parameter int TENANTS      = 8,
	parameter int PAGE_BITS    = 20
) (
	input logic clk,
	input logic arst_n,
	pltlru_if.sink   req,
	pltlru_if.source rsp,
	pltlru_if.sink   cfg
);
	localparam int TW = pltlru_pkg::TENANT_W;
	localparam int LW = pltlru_pkg::LOC_W;
	localparam int N  = BUFFER_SLOTS;
	localparam int IW = $clog2(N);
	localparam int CW = $clog2(N + 1);

	// Payload fields as seen in the interface structs.
	logic [2:0]         r_action;
	logic [TW-1:0]      r_tenant;
	logic [19:0]        r_page_in;
	logic [LW-1:0]      r_newloc;
	assign r_action  = req.data.action;
	assign r_tenant  = req.data.tenant;
	assign r_page_in = req.data.page_number;
	assign r_newloc  = req.data.new_location;

	pltlru_pkg::fsm_t state_q, state_d;

	// Request registers
	pltlru_pkg::action_t act_q;
	logic [TW-1:0]        ten_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [LW-1:0]        nloc_q;
	logic                 tvalid_q;
	logic                 known_q;

	// Search results
	logic [IW-1:0] hit_idx_s1, lru_idx_s1;
	logic          hit_s1, tany_s1;
	logic [CW-1:0] used_q;

	// Cell chain wiring
	logic                 c_valid  [N];
	logic [TW-1:0]        c_tenant [N];
	logic [PAGE_BITS-1:0] c_page   [N];
	logic [LW-1:0]        c_loc    [N];
	logic [N-1:0]         c_match, c_tmatch, c_shift;
	pltlru_pkg::cell_cmd_t cmd;
	logic [IW-1:0]        mark;
	logic                 hv; logic [TW-1:0] ht; logic [PAGE_BITS-1:0] hp; logic [LW-1:0] hl;

	// Output register
	logic          rsp_valid_q;
	logic [LW-1:0] o_loc_q, o_loc_d;
	logic          o_hit_q, o_hit_d;
	logic [19:0]   o_vic_q, o_vic_d;
	pltlru_pkg::status_t o_st_q, o_st_d;

	logic pool_busy, pool_empty, pool_pop;
	logic [LW-1:0] pool_loc;

	pltlru_pool #(.SLOTS(N)) u_pool (
		.clk, .arst_n,
		.reload(cfg.valid && cfg.ready), .count_in(cfg.data),
		.pop(pool_pop), .busy(pool_busy), .empty(pool_empty),
		.head_loc_q(pool_loc)
	);

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			logic                 sv; logic [TW-1:0] st; logic [PAGE_BITS-1:0] sp;
			logic [LW-1:0] sl;
			if (g == 0) begin : g_head
				always_comb begin
					if (cmd == pltlru_pkg::CC_PUSH) begin
						sv = hv; st = ht; sp = hp; sl = hl;
					end else begin
						sv = (N > 1) ? c_valid[(g+1)%N] : 1'b0;
						st = c_tenant[(g+1)%N]; sp = c_page[(g+1)%N];
						sl = c_loc[(g+1)%N];
					end
				end
			end else if (g == N-1) begin : g_tail
				always_comb begin
					if (cmd == pltlru_pkg::CC_PUSH) begin
						sv = c_valid[g-1]; st = c_tenant[g-1]; sp = c_page[g-1];
						sl = c_loc[g-1];
					end else begin
						sv = 1'b0; st = c_tenant[g]; sp = c_page[g]; sl = c_loc[g];
					end
				end
			end else begin : g_mid
				always_comb begin
					if (cmd == pltlru_pkg::CC_PUSH) begin
						sv = c_valid[g-1]; st = c_tenant[g-1]; sp = c_page[g-1];
						sl = c_loc[g-1];
					end else begin
						sv = c_valid[g+1]; st = c_tenant[g+1]; sp = c_page[g+1];
						sl = c_loc[g+1];
					end
				end
			end
			// push: slots 0..mark take left neighbour; close: slots mark.. take right
			assign c_shift[g] = (cmd == pltlru_pkg::CC_PUSH) ? (IW'(g) <= mark) :
				(IW'(g) >= mark);
			pltlru_cell #(.PAGE_BITS(PAGE_BITS)) u_cell (
				.clk, .arst_n, .cmd, .shift_en(c_shift[g]), .load_head(1'b0),
				.nb_valid(sv), .nb_tenant(st), .nb_page(sp), .nb_loc(sl),
				.key_tenant(ten_q), .key_page(page_q),
				.valid_q(c_valid[g]), .tenant_q(c_tenant[g]), .page_q(c_page[g]),
				.loc_q(c_loc[g]), .match(c_match[g]), .tmatch(c_tmatch[g])
			);
		end
	endgenerate

	// Priority encoders: first match (pages are unique), last tenant match.
	logic [IW-1:0] fi, li; logic fa, la;
	always_comb begin
		fi = '0; fa = 1'b0; li = '0; la = 1'b0;
		for (int k = N-1; k >= 0; k--) begin
			if (c_match[k]) begin fi = IW'(k); fa = 1'b1; end
		end
		for (int k = 0; k < N; k++) begin
			if (c_tmatch[k]) begin li = IW'(k); la = 1'b1; end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pltlru_pkg::FS_SEARCH) begin
			hit_idx_s1 <= fi; hit_s1 <= fa && tvalid_q;
			lru_idx_s1 <= li; tany_s1 <= la && tvalid_q;
		end
	end

	assign req.ready = state_q == pltlru_pkg::FS_IDLE && !pool_busy;
	assign cfg.ready = state_q == pltlru_pkg::FS_IDLE;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pltlru_pkg::FS_IDLE:   if (req.valid && req.ready) state_d = pltlru_pkg::FS_SEARCH;
			pltlru_pkg::FS_SEARCH: state_d = pltlru_pkg::FS_APPLY;
			pltlru_pkg::FS_APPLY:  state_d = pltlru_pkg::FS_RELOAD;
			pltlru_pkg::FS_RELOAD: if (!rsp_valid_q || rsp.ready) state_d = pltlru_pkg::FS_IDLE;
			default:               state_d = pltlru_pkg::FS_IDLE;
		endcase
	end

	// Chain command and result of the apply step
	always_comb begin
		cmd = pltlru_pkg::CC_NONE; mark = '0;
		hv = 1'b1; ht = ten_q; hp = page_q; hl = nloc_q;
		o_loc_d = '0; o_hit_d = 1'b0; o_vic_d = '0; o_st_d = pltlru_pkg::ST_OK;
		pool_pop = 1'b0;
		if (state_q == pltlru_pkg::FS_APPLY && known_q) begin
			unique case (act_q)
				pltlru_pkg::ACT_LOOKUP: begin
					if (hit_s1) begin o_loc_d = c_loc[hit_idx_s1]; o_hit_d = 1'b1; end
				end
				pltlru_pkg::ACT_TOUCH: begin
					if (hit_s1) begin
						o_loc_d = c_loc[hit_idx_s1];
						cmd = pltlru_pkg::CC_PUSH; mark = hit_idx_s1;
						hl = c_loc[hit_idx_s1];
					end else o_st_d = pltlru_pkg::ST_MISSING;
				end
				pltlru_pkg::ACT_ADD: begin
					if (!tvalid_q) o_st_d = pltlru_pkg::ST_EMPTY_T;
					else if (hit_s1) o_st_d = pltlru_pkg::ST_PRESENT;
					else if (used_q >= CW'(N)) o_st_d = pltlru_pkg::ST_POOL_MT;
					else begin cmd = pltlru_pkg::CC_PUSH; mark = used_q[IW-1:0]; end
				end
				pltlru_pkg::ACT_EVICT: begin
					if (tany_s1) begin
						o_loc_d = c_loc[lru_idx_s1];
						o_vic_d = 20'(c_page[lru_idx_s1]);
						cmd = pltlru_pkg::CC_CLOSE; mark = lru_idx_s1;
					end else o_st_d = pltlru_pkg::ST_EMPTY_T;
				end
				pltlru_pkg::ACT_ALLOC: begin
					if (pool_empty) o_st_d = pltlru_pkg::ST_POOL_MT;
					else begin o_loc_d = pool_loc; pool_pop = 1'b1; end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pltlru_pkg::FS_IDLE;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd == pltlru_pkg::CC_PUSH && act_q == pltlru_pkg::ACT_ADD) used_q <= used_q + 1'b1;
			if (cmd == pltlru_pkg::CC_CLOSE) used_q <= used_q - 1'b1;
			// a new load wins over the hand-off of the old response
			if (state_q == pltlru_pkg::FS_RELOAD && (!rsp_valid_q || rsp.ready))
				rsp_valid_q <= 1'b1;
			else if (rsp.valid && rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	logic [LW-1:0] p_loc_q; logic p_hit_q; logic [19:0] p_vic_q; pltlru_pkg::status_t p_st_q;
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_q    <= pltlru_pkg::action_t'(r_action);
			known_q  <= r_action <= pltlru_pkg::ACT_ALLOC;
			ten_q    <= r_tenant;
			page_q   <= PAGE_BITS'(r_page_in);
			nloc_q   <= r_newloc;
			tvalid_q <= r_tenant >= TW'(1) && 32'(r_tenant) <= TENANTS;
		end
		if (state_q == pltlru_pkg::FS_APPLY) begin
			p_loc_q <= o_loc_d; p_hit_q <= o_hit_d; p_vic_q <= o_vic_d; p_st_q <= o_st_d;
		end
		if (state_q == pltlru_pkg::FS_RELOAD && (!rsp_valid_q || rsp.ready)) begin
			o_loc_q <= p_loc_q; o_hit_q <= p_hit_q; o_vic_q <= p_vic_q; o_st_q <= p_st_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data.location    = o_loc_q;
	assign rsp.data.hit         = o_hit_q;
	assign rsp.data.victim_page = o_vic_q;
	assign rsp.data.status      = o_st_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n) used_q <= CW'(N))
		else $error("cell count overflow");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pool_pop |-> !pool_empty) else $error("pop from empty ring");
	a_req_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> state_q == pltlru_pkg::FS_SEARCH)
		else $error("request not started");
	a_hit_only_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.hit) |-> rsp.data.status == pltlru_pkg::ST_OK)
		else $error("hit with error status");
endmodule

FILE: tb/pltlru_checker.sv
// Response checker for the per-tenant LRU page table testbench.
// Depends on pltlru_pkg and pltlru_if; predicts every response and compares field by field.
`timescale 1ns / 100ps

module pltlru_checker (
	input  logic clk,
	input  logic arst_n,
	pltlru_if    req,
	pltlru_if    rsp,
	pltlru_if    cfg,
	output int   fail_count,
	output int   pending
);
	localparam int SLOTS       = 1024;
	localparam int TENANTS     = 8;
	localparam int RESET_SLOTS = 1024;

	typedef struct {
		logic [3:0]  tenant;
		logic [19:0] page;
		logic [10:0] loc;
	} page_entry_t;

	page_entry_t           recency_q[$];   // most recent first
	logic [10:0]           free_ring[SLOTS];
	int                    free_head;
	int                    free_count;
	pltlru_pkg::page_rsp_t expected_q[$];
	int                    fail_n = 0;
	int                    pending_n = 0;

	assign fail_count = fail_n;
	assign pending    = pending_n;

	function automatic int find_page(logic [3:0] t, logic [19:0] pg);
		for (int i = 0; i < recency_q.size(); i++)
			if (recency_q[i].tenant == t && recency_q[i].page == pg)
				return i;
		return -1;
	endfunction

	task automatic reload_pool(pltlru_pkg::slots_t v);
		int n;
		n = (v > SLOTS) ? SLOTS : v;
		for (int i = 0; i < SLOTS; i++)
			free_ring[i] = (i < n) ? 11'(i + 1) : 11'd0;
		free_head  = 0;
		free_count = n;
	endtask

	task automatic predict_response(pltlru_pkg::page_req_t r);
		pltlru_pkg::page_rsp_t e;
		page_entry_t           c;
		logic                  tok;
		int                    i;
		e   = '0;
		tok = (r.tenant >= 1 && r.tenant <= TENANTS);
		i   = tok ? find_page(r.tenant, r.page_number) : -1;
		case (r.action)
			pltlru_pkg::ACT_LOOKUP: if (i >= 0) begin
				e.location = recency_q[i].loc;
				e.hit      = 1'b1;
			end
			pltlru_pkg::ACT_TOUCH: if (i >= 0) begin
				c = recency_q[i];
				recency_q.delete(i);
				recency_q.insert(0, c);
				e.location = c.loc;
			end else begin
				e.status = pltlru_pkg::ST_MISSING;
			end
			pltlru_pkg::ACT_ADD: begin
				if (!tok)
					e.status = pltlru_pkg::ST_EMPTY_T;
				else if (i >= 0)
					e.status = pltlru_pkg::ST_PRESENT;
				else if (recency_q.size() >= SLOTS)
					e.status = pltlru_pkg::ST_POOL_MT;
				else begin
					c.tenant = r.tenant;
					c.page   = r.page_number;
					c.loc    = r.new_location;
					recency_q.insert(0, c);
				end
			end
			pltlru_pkg::ACT_EVICT: begin
				i = -1;
				if (tok)
					for (int k = 0; k < recency_q.size(); k++)
						if (recency_q[k].tenant == r.tenant)
							i = k;
				if (i >= 0) begin
					e.location    = recency_q[i].loc;
					e.victim_page = recency_q[i].page;
					recency_q.delete(i);
				end else begin
					e.status = pltlru_pkg::ST_EMPTY_T;
				end
			end
			pltlru_pkg::ACT_ALLOC: if (free_count == 0) begin
				e.status = pltlru_pkg::ST_POOL_MT;
			end else begin
				e.location = free_ring[free_head];
				free_head  = (free_head + 1) % SLOTS;
				free_count--;
			end
			default: ;
		endcase
		expected_q.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pltlru_pkg::page_rsp_t e;
		if (!arst_n) begin
			recency_q.delete();
			expected_q.delete();
			reload_pool(pltlru_pkg::slots_t'(RESET_SLOTS));
		end else begin
			if (cfg.valid && cfg.ready)
				reload_pool(cfg.data);
			if (req.valid && req.ready)
				predict_response(req.data);
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: response with none outstanding: %p", $time, rsp.data);
					fail_n++;
				end else begin
					e = expected_q.pop_front();
					if (rsp.data.location !== e.location) begin
						$display("%0t: location exp %0d got %0d", $time, e.location,
							rsp.data.location);
						fail_n++;
					end
					if (rsp.data.hit !== e.hit) begin
						$display("%0t: hit exp %0d got %0d", $time, e.hit, rsp.data.hit);
						fail_n++;
					end
					if (rsp.data.victim_page !== e.victim_page) begin
						$display("%0t: victim_page exp %h got %h", $time, e.victim_page,
							rsp.data.victim_page);
						fail_n++;
					end
					if (rsp.data.status !== e.status) begin
						$display("%0t: status exp %0d got %0d", $time, e.status,
							rsp.data.status);
						fail_n++;
					end
				end
			end
		end
		pending_n = expected_q.size();
	end
endmodule

FILE: tb/per_tenant_lru_page_table_tb.sv
// Top of the per-tenant LRU page table testbench: clock, reset, stimulus and verdict.
// Depends on pltlru_pkg, pltlru_if, pltlru_checker and the block itself.
`timescale 1ns / 100ps

module per_tenant_lru_page_table_tb;
	localparam int CYCLE_LIMIT = 600000;

	logic clk;
	logic arst_n;
	int   send_idle_pct;   // chance of a gap after a request transfer
	int   recv_idle_pct;   // chance of rsp.ready low in a cycle
	int   cycles;
	int   fail_count;
	int   pending;

	pltlru_if #(.T(pltlru_pkg::page_req_t)) req ();
	pltlru_if #(.T(pltlru_pkg::page_rsp_t)) rsp ();
	pltlru_if #(.T(pltlru_pkg::slots_t))    cfg ();

	per_tenant_lru_page_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	pltlru_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: once the cycle counter reaches CYCLE_LIMIT, the run ends here as failed.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Receiver side: ready chosen afresh every cycle.
	always @(posedge clk)
		rsp.ready <= ($urandom_range(99) >= recv_idle_pct);

	// One request transfer; valid stays high into the next request unless a
	// gap is drawn, so valid never drops and rises within one step.
	task automatic send_request(pltlru_pkg::action_t a, logic [3:0] t, logic [19:0] pg,
		logic [10:0] loc);
		pltlru_pkg::page_req_t r;
		int                    gap;
		r.action       = a;
		r.tenant       = t;
		r.page_number  = pg;
		r.new_location = loc;
		req.valid <= 1'b1;
		req.data  <= r;
		do @(posedge clk); while (!req.ready);
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Quiesce: lower valid, let all responses drain, then let the
	// pipeline settle before touching the register.
	task automatic drain;
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_slots(pltlru_pkg::slots_t v);
		drain();
		cfg.valid <= 1'b1;
		cfg.data  <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random request mix. Pages mostly from a small set so lookups, touches
	// and duplicate adds actually hit; occasional full-width noise.
	task automatic random_requests(int n);
		pltlru_pkg::action_t a;
		logic [3:0]          t;
		logic [19:0]         pg;
		logic [10:0]         loc;
		int                  w;
		for (int i = 0; i < n; i++) begin
			w = $urandom_range(99);
			if (w < 25)      a = pltlru_pkg::ACT_LOOKUP;
			else if (w < 42) a = pltlru_pkg::ACT_TOUCH;
			else if (w < 64) a = pltlru_pkg::ACT_ADD;
			else if (w < 82) a = pltlru_pkg::ACT_EVICT;
			else if (w < 96) a = pltlru_pkg::ACT_ALLOC;
			else             a = pltlru_pkg::action_t'($urandom_range(5, 7));
			t   = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
				: 4'($urandom_range(1, 8));
			pg  = ($urandom_range(7) == 0) ? 20'($urandom) : 20'($urandom_range(40));
			loc = 11'($urandom);
			send_request(a, t, pg, loc);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.data      = '0;
		cfg.valid     = 1'b0;
		cfg.data      = '0;
		send_idle_pct = 20;
		recv_idle_pct = 78;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: miss, extremes of fields, every action, the missing, duplicate and bad-tenant errors and unknown codes.
		send_request(pltlru_pkg::ACT_LOOKUP, 4'd1, 20'd0, 11'd0);
		send_request(pltlru_pkg::ACT_ADD,    4'd1, 20'd0, 11'd1);
		send_request(pltlru_pkg::ACT_ADD,    4'd8, 20'hFFFFF, 11'd2047);
		send_request(pltlru_pkg::ACT_ADD,    4'd2, 20'h5A5A5, 11'd0);
		send_request(pltlru_pkg::ACT_ADD,    4'd1, 20'd0, 11'd5);          // duplicate
		send_request(pltlru_pkg::ACT_LOOKUP, 4'd8, 20'hFFFFF, 11'd0);      // hit
		send_request(pltlru_pkg::ACT_TOUCH,  4'd1, 20'd0, 11'd0);          // good touch
		send_request(pltlru_pkg::ACT_TOUCH,  4'd1, 20'd7, 11'd0);          // missing page
		send_request(pltlru_pkg::ACT_TOUCH,  4'd0, 20'd0, 11'd0);          // tenant zero
		send_request(pltlru_pkg::ACT_ADD,    4'd0, 20'd3, 11'd3);          // tenant out of range
		send_request(pltlru_pkg::ACT_ADD,    4'd15, 20'd3, 11'd3);
		send_request(pltlru_pkg::ACT_LOOKUP, 4'd9, 20'd0, 11'd0);
		send_request(pltlru_pkg::ACT_EVICT,  4'd1, 20'd0, 11'd0);
		send_request(pltlru_pkg::ACT_EVICT,  4'd1, 20'd0, 11'd0);          // tenant now empty
		send_request(pltlru_pkg::ACT_EVICT,  4'd0, 20'd0, 11'd0);
		send_request(pltlru_pkg::ACT_EVICT,  4'd12, 20'd0, 11'd0);
		send_request(pltlru_pkg::ACT_ALLOC,  4'd3, 20'd0, 11'd0);
		send_request(pltlru_pkg::action_t'(3'd5), 4'd3, 20'hFFFFF, 11'd2047);
		send_request(pltlru_pkg::action_t'(3'd6), 4'd3, 20'd0, 11'd0);
		send_request(pltlru_pkg::action_t'(3'd7), 4'd3, 20'd0, 11'd0);

		// Pool of one, then empty pool, then a value beyond the table size.
		write_slots(11'd1);
		send_request(pltlru_pkg::ACT_ALLOC, 4'd1, 20'd0, 11'd0);
		send_request(pltlru_pkg::ACT_ALLOC, 4'd1, 20'd0, 11'd0);
		write_slots(11'd0);
		send_request(pltlru_pkg::ACT_ALLOC, 4'd1, 20'd0, 11'd0);
		write_slots(11'd2047);
		send_request(pltlru_pkg::ACT_ALLOC, 4'd1, 20'd0, 11'd0);

		// Fill the table past capacity with distinct pages: last adds refused.
		for (int i = 0; i < 1030; i++)
			send_request(pltlru_pkg::ACT_ADD, 4'($urandom_range(1, 8)), 20'(i),
				11'($urandom));
		random_requests(220);

		send_idle_pct = 78;
		recv_idle_pct = 20;
		write_slots(11'($urandom_range(1, 1024)));
		random_requests(220);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_slots(11'd1024);
		random_requests(220);

		drain();
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
